@@ src/omr_pkg.sv @@
// ----------------------------------------------------------------------------
// omr_pkg: shared definitions for the oversampled majority bit receiver
// Field widths, register map codes and register reset values.
// ----------------------------------------------------------------------------
package omr_pkg;

    localparam int THRESHOLD_W  = 10;
    localparam int SPB_W        = 6;
    localparam int MSG_BITS_W   = 7;
    localparam int TIMEOUT_W    = 24;
    localparam int HIGH_COUNT_W = 6;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef logic [1:0] reg_index_t;

    localparam reg_index_t REG_THRESHOLD = 2'd0;
    localparam reg_index_t REG_SPB       = 2'd1;
    localparam reg_index_t REG_MSG_BITS  = 2'd2;
    localparam reg_index_t REG_TIMEOUT   = 2'd3;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 10'd500;
    localparam logic [SPB_W-1:0]       SPB_RST       = 6'd25;
    localparam logic [MSG_BITS_W-1:0]  MSG_BITS_RST  = 7'd8;
    localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RST   = 24'd65535;

endpackage

@@ src/omr_if.sv @@
// ----------------------------------------------------------------------------
// omr_if: request channels of the oversampled majority bit receiver
// Sample channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface omr_sample_if #(
    parameter int SAMPLE_WIDTH = 10
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface omr_result_if;
    import omr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    bit_value;
    logic                    is_last;
    logic                    timed_out;
    logic [HIGH_COUNT_W-1:0] high_count;

    modport source (output valid, output bit_value, output is_last, output timed_out,
                    output high_count, input ready);
    modport sink   (input valid, input bit_value, input is_last, input timed_out,
                    input high_count, output ready);
endinterface

@@ src/oversampled_majority_bit_receiver.sv @@
// ----------------------------------------------------------------------------
// oversampled_majority_bit_receiver: threshold, hunt and majority-vote receiver
// Hunts for a start sample, then votes samples_per_bit samples into each of
// message_bits bits; reports a timeout when hunting runs too long.
// ----------------------------------------------------------------------------
//  channel     dir   payload                                        handshake
//  sample_ch   in    sample                                         valid/ready
//  result_ch   out   bit_value, is_last, timed_out, high_count      valid/ready
//  apb         in    sample_threshold, samples_per_bit,             psel/penable
//                    message_bits, idle_timeout
//
// One sample is accepted per clock cycle unless a stall holds ready low. A
// sample goes through an input register and the combinational compare and
// count logic into the result register. Reset clears all counters and loads
// the register defaults. A stalled result holds the pipeline; the input
// register still fills and ready drops only while both the input and the
// result register are full.
// ----------------------------------------------------------------------------
module oversampled_majority_bit_receiver #(
    parameter int SAMPLE_WIDTH     = 10,
    parameter int MAX_MESSAGE_BITS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [omr_pkg::ADDR_W-1:0] paddr,
    input  logic [omr_pkg::DATA_W-1:0] pwdata,
    output logic [omr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    omr_sample_if.sink                 sample_ch,
    omr_result_if.source               result_ch
);
    import omr_pkg::*;

    localparam int CMP_W = (SAMPLE_WIDTH > THRESHOLD_W) ? SAMPLE_WIDTH : THRESHOLD_W;
    localparam logic [MSG_BITS_W:0] MAX_BITS = (MSG_BITS_W+1)'(MAX_MESSAGE_BITS);

    // Configuration registers
    logic [THRESHOLD_W-1:0] threshold_reg;
    logic [SPB_W-1:0]       spb_reg;
    logic [MSG_BITS_W-1:0]  msg_bits_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;

    logic       cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            spb_reg       <= SPB_RST;
            msg_bits_reg  <= MSG_BITS_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= pwdata[THRESHOLD_W-1:0];
                REG_SPB:       spb_reg       <= pwdata[SPB_W-1:0];
                REG_MSG_BITS:  msg_bits_reg  <= pwdata[MSG_BITS_W-1:0];
                REG_TIMEOUT:   timeout_reg   <= pwdata[TIMEOUT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_THRESHOLD: prdata = DATA_W'(threshold_reg);
            REG_SPB:       prdata = DATA_W'(spb_reg);
            REG_MSG_BITS:  prdata = DATA_W'(msg_bits_reg);
            REG_TIMEOUT:   prdata = DATA_W'(timeout_reg);
            default:       prdata = '0;
        endcase
    end

    // Input register
    logic                    in_valid_reg;
    logic [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic                    advance;

    assign advance         = in_valid_reg && (!result_ch.valid || result_ch.ready);
    assign sample_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample_ch.ready)
            in_valid_reg <= sample_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
            in_sample_reg <= sample_ch.sample;
    end

    // Receiver state
    logic                    collecting_reg, collecting_next;
    logic [TIMEOUT_W-1:0]    hunt_count_reg, hunt_count_next;
    logic [SPB_W-1:0]        sample_index_reg, sample_index_next;
    logic [HIGH_COUNT_W-1:0] ones_sum_reg, ones_sum_next;
    logic [MSG_BITS_W-1:0]   bit_index_reg, bit_index_next;

    logic                    emit;
    logic                    bit_value_next;
    logic                    is_last_next;
    logic                    timed_out_next;
    logic [HIGH_COUNT_W-1:0] high_count_next;

    logic                    high;
    logic [SPB_W-1:0]        spb_eff;
    logic [MSG_BITS_W:0]     nbits_eff;
    logic [TIMEOUT_W-1:0]    tmo_eff;
    logic [TIMEOUT_W-1:0]    hunt_inc;
    logic [SPB_W-1:0]        index_inc;
    logic [HIGH_COUNT_W-1:0] ones_inc;
    logic [MSG_BITS_W:0]     bits_done;
    logic                    bit_end;
    logic                    last_bit;

    always_comb
    begin
        high    = CMP_W'(in_sample_reg) > CMP_W'(threshold_reg);
        spb_eff = (spb_reg == '0) ? SPB_W'(1) : spb_reg;
        tmo_eff = (timeout_reg == '0) ? TIMEOUT_W'(1) : timeout_reg;
        if (msg_bits_reg == '0)
            nbits_eff = (MSG_BITS_W+1)'(1);
        else if ({1'b0, msg_bits_reg} > MAX_BITS)
            nbits_eff = MAX_BITS;
        else
            nbits_eff = {1'b0, msg_bits_reg};

        hunt_inc  = hunt_count_reg + TIMEOUT_W'(1);
        index_inc = sample_index_reg + SPB_W'(1);
        ones_inc  = ones_sum_reg + HIGH_COUNT_W'(high);
        bits_done = {1'b0, bit_index_reg} + (MSG_BITS_W+1)'(1);
        bit_end   = (index_inc >= spb_eff) || (index_inc == '0);
        last_bit  = bits_done >= nbits_eff;

        collecting_next   = collecting_reg;
        hunt_count_next   = hunt_count_reg;
        sample_index_next = sample_index_reg;
        ones_sum_next     = ones_sum_reg;
        bit_index_next    = bit_index_reg;
        emit              = 1'b0;
        bit_value_next    = 1'b0;
        is_last_next      = 1'b0;
        timed_out_next    = 1'b0;
        high_count_next   = '0;

        if (!collecting_reg)
        begin
            if (high)
            begin
                // Start sample: dropped, message counters cleared.
                collecting_next   = 1'b1;
                hunt_count_next   = '0;
                sample_index_next = '0;
                ones_sum_next     = '0;
                bit_index_next    = '0;
            end
            else if ((hunt_inc >= tmo_eff) || (hunt_inc == '0))
            begin
                hunt_count_next = '0;
                emit            = 1'b1;
                timed_out_next  = 1'b1;
            end
            else
            begin
                hunt_count_next = hunt_inc;
            end
        end
        else if (bit_end)
        begin
            emit              = 1'b1;
            // Strict majority: twice the count exceeds the bit length.
            bit_value_next    = {ones_inc, 1'b0} > (HIGH_COUNT_W+1)'(spb_eff);
            is_last_next      = last_bit;
            high_count_next   = ones_inc;
            sample_index_next = '0;
            ones_sum_next     = '0;
            if (last_bit)
            begin
                collecting_next = 1'b0;
                bit_index_next  = '0;
                hunt_count_next = '0;
            end
            else
            begin
                bit_index_next = bits_done[MSG_BITS_W-1:0];
            end
        end
        else
        begin
            sample_index_next = index_inc;
            ones_sum_next     = ones_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg   <= 1'b0;
            hunt_count_reg   <= '0;
            sample_index_reg <= '0;
            ones_sum_reg     <= '0;
            bit_index_reg    <= '0;
        end
        else if (advance)
        begin
            collecting_reg   <= collecting_next;
            hunt_count_reg   <= hunt_count_next;
            sample_index_reg <= sample_index_next;
            ones_sum_reg     <= ones_sum_next;
            bit_index_reg    <= bit_index_next;
        end
    end

    // Result register
    logic                    out_valid_reg;
    logic                    bit_value_reg;
    logic                    is_last_reg;
    logic                    timed_out_reg;
    logic [HIGH_COUNT_W-1:0] high_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || result_ch.ready)
            out_valid_reg <= advance && emit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            bit_value_reg  <= bit_value_next;
            is_last_reg    <= is_last_next;
            timed_out_reg  <= timed_out_next;
            high_count_reg <= high_count_next;
        end
    end

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.bit_value  = bit_value_reg;
    assign result_ch.is_last    = is_last_reg;
    assign result_ch.timed_out  = timed_out_reg;
    assign result_ch.high_count = high_count_reg;

endmodule

@@ dv/oversampled_majority_bit_receiver_test.sv @@
// ----------------------------------------------------------------------------
// oversampled_majority_bit_receiver_test: self-checking bench for the receiver
// Programs the registers over APB, walks a table of directed samples and then
// random message-shaped sample streams under several idle and stall patterns.
// Every result request is compared against the table's expected result or a
// cycle-free prediction of the hunt, vote and timeout behavior.
// ----------------------------------------------------------------------------
module oversampled_majority_bit_receiver_test;
    import omr_pkg::*;

    localparam int SAMPLE_WIDTH     = 10;
    localparam int MAX_MESSAGE_BITS = 64;
    localparam int NUM_PHASES       = 8;
    localparam int PHASE_ITEMS      = 170;
    localparam int DIRECTED_LEN     = 24;
    localparam int REPORT_LIMIT     = 10;
    localparam int SETTLE_CYCLES    = 6;

    typedef logic [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        logic                    bit_value;
        logic                    is_last;
        logic                    timed_out;
        logic [HIGH_COUNT_W-1:0] high_count;
    } bit_result_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_TYPED
    } row_kind_t;

    typedef struct packed {
        sample_t     smp;
        row_kind_t   kind;
        bit_result_t want;
    } stim_row_t;

    localparam bit_result_t NO_RESULT = '0;

    // Registers for this table: threshold 500, 3 samples per bit, 2 bits,
    // timeout after 3 hunting samples.
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{10'd0,    ROW_QUIET,   NO_RESULT},
        '{10'd500,  ROW_QUIET,   NO_RESULT},
        '{10'd499,  ROW_TYPED,   '{1'b0, 1'b0, 1'b1, 6'd0}},
        '{10'd501,  ROW_QUIET,   NO_RESULT},
        '{10'd1023, ROW_QUIET,   NO_RESULT},
        '{10'd0,    ROW_QUIET,   NO_RESULT},
        '{10'd1023, ROW_TYPED,   '{1'b1, 1'b0, 1'b0, 6'd2}},
        '{10'd0,    ROW_QUIET,   NO_RESULT},
        '{10'd0,    ROW_QUIET,   NO_RESULT},
        '{10'd501,  ROW_TYPED,   '{1'b0, 1'b1, 1'b0, 6'd1}},
        '{10'd1023, ROW_QUIET,   NO_RESULT},
        '{10'd1023, ROW_QUIET,   NO_RESULT},
        '{10'd1023, ROW_QUIET,   NO_RESULT},
        '{10'd1023, ROW_TYPED,   '{1'b1, 1'b0, 1'b0, 6'd3}},
        '{10'd0,    ROW_QUIET,   NO_RESULT},
        '{10'd0,    ROW_QUIET,   NO_RESULT},
        '{10'd0,    ROW_TYPED,   '{1'b0, 1'b1, 1'b0, 6'd0}},
        '{10'd0,    ROW_QUIET,   NO_RESULT},
        '{10'd0,    ROW_QUIET,   NO_RESULT},
        '{10'd0,    ROW_TYPED,   '{1'b0, 1'b0, 1'b1, 6'd0}},
        '{10'd1023, ROW_QUIET,   NO_RESULT},
        '{10'd501,  ROW_PREDICT, NO_RESULT},
        '{10'd500,  ROW_PREDICT, NO_RESULT},
        '{10'd999,  ROW_PREDICT, NO_RESULT}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    omr_sample_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) sample_ch ();
    omr_result_if result_ch ();

    oversampled_majority_bit_receiver #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .MAX_MESSAGE_BITS (MAX_MESSAGE_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    always #5 clk = ~clk;

    // Register mirror and receiver state of the prediction.
    logic [THRESHOLD_W-1:0]  rx_threshold;
    logic [SPB_W-1:0]        rx_spb;
    logic [MSG_BITS_W-1:0]   rx_msg_bits;
    logic [TIMEOUT_W-1:0]    rx_timeout;
    logic                    rx_collecting;
    logic [TIMEOUT_W-1:0]    rx_hunt;
    logic [SPB_W-1:0]        rx_sample_idx;
    logic [HIGH_COUNT_W-1:0] rx_ones;
    logic [MSG_BITS_W-1:0]   rx_bit_idx;

    bit_result_t expected_bits [$];
    int          mismatches;
    int          bits_seen;
    int          ends_seen;
    int          timeouts_seen;
    int          samples_sent;
    int          settings_used;
    int          sender_idle_pct;
    int          stall_pct;

    function automatic int eff_spb();
        return (rx_spb == '0) ? 1 : int'(rx_spb);
    endfunction

    function automatic int eff_bits();
        int nbits;
        nbits = (rx_msg_bits == '0) ? 1 : int'(rx_msg_bits);
        return (nbits > MAX_MESSAGE_BITS) ? MAX_MESSAGE_BITS : nbits;
    endfunction

    function automatic int eff_timeout();
        return (rx_timeout == '0) ? 1 : int'(rx_timeout);
    endfunction

    // Advances the receiver by one sample; returns one when a result is due.
    function automatic bit vote_sample(input sample_t smp, output bit_result_t res);
        logic above;
        int   cnt;
        bit   last;
        above = smp > rx_threshold;
        res   = NO_RESULT;
        if (!rx_collecting)
        begin
            if (above)
            begin
                rx_collecting = 1'b1;
                rx_hunt       = '0;
                rx_sample_idx = '0;
                rx_ones       = '0;
                rx_bit_idx    = '0;
                return 1'b0;
            end
            rx_hunt = rx_hunt + 1'b1;
            if (int'(rx_hunt) >= eff_timeout() || rx_hunt == '0)
            begin
                rx_hunt       = '0;
                res.timed_out = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        end
        if (above)
            rx_ones = rx_ones + 1'b1;
        rx_sample_idx = rx_sample_idx + 1'b1;
        if (int'(rx_sample_idx) >= eff_spb() || rx_sample_idx == '0)
        begin
            cnt            = int'(rx_ones);
            last           = (int'(rx_bit_idx) + 1) >= eff_bits();
            res.bit_value  = (2 * cnt) > eff_spb();
            res.is_last    = last;
            res.high_count = rx_ones;
            rx_sample_idx  = '0;
            rx_ones        = '0;
            if (last)
            begin
                rx_collecting = 1'b0;
                rx_bit_idx    = '0;
                rx_hunt       = '0;
            end
            else
            begin
                rx_bit_idx = rx_bit_idx + 1'b1;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // On the requested side of the threshold, now and then at or just above it; at threshold 1023 a high gives 1023.
    function automatic sample_t level_sample(input bit level);
        int thr;
        thr = int'(rx_threshold);
        if (level)
        begin
            if (thr >= 1023)
                return sample_t'(1023);
            if ($urandom_range(0, 9) == 0)
                return sample_t'(thr + 1);
            return sample_t'($urandom_range(1023, thr + 1));
        end
        if ($urandom_range(0, 9) == 0)
            return sample_t'(thr);
        return sample_t'($urandom_range(thr, 0));
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_THRESHOLD: rx_threshold = value[THRESHOLD_W-1:0];
            REG_SPB:       rx_spb       = value[SPB_W-1:0];
            REG_MSG_BITS:  rx_msg_bits  = value[MSG_BITS_W-1:0];
            REG_TIMEOUT:   rx_timeout   = value[TIMEOUT_W-1:0];
            default: ;
        endcase
    endtask

    // Upper bits beyond each register's width are noise and must be ignored.
    task automatic program_receiver(input int thr, input int spb, input int nbits,
                                    input int tmo);
        write_reg(REG_THRESHOLD, DATA_W'(thr) | ($urandom << THRESHOLD_W));
        write_reg(REG_SPB,       DATA_W'(spb) | ($urandom << SPB_W));
        write_reg(REG_MSG_BITS,  DATA_W'(nbits) | ($urandom << MSG_BITS_W));
        write_reg(REG_TIMEOUT,   DATA_W'(tmo) | ($urandom << TIMEOUT_W));
        settings_used++;
    endtask

    task automatic offer_sample(input sample_t smp, input row_kind_t kind,
                                input bit_result_t want);
        bit_result_t res;
        bit          due;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= smp;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        samples_sent++;
        due = vote_sample(smp, res);
        case (kind)
            ROW_TYPED:   expected_bits.push_back(want);
            ROW_PREDICT: if (due) expected_bits.push_back(res);
            default: ;
        endcase
    endtask

    task automatic send_random(input sample_t smp);
        offer_sample(smp, ROW_PREDICT, NO_RESULT);
    endtask

    // Holds the sample channel quiet until every expected result has arrived,
    // then keeps it quiet while the pipeline empties out.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic pick_setting(input int phase);
        case (phase)
            0: program_receiver(0, 1, 64, 1);
            1: program_receiver(1023, 5, 3, 0);
            2: program_receiver($urandom_range(100, 900), 63, 1, 24'hFFFFFF);
            3: program_receiver($urandom_range(100, 900), 0, 0, $urandom_range(1, 40));
            4: program_receiver($urandom_range(100, 900), 2, 127, $urandom_range(1, 60));
            default: program_receiver($urandom_range(0, 1023), $urandom_range(1, 10),
                                      $urandom_range(1, 10), $urandom_range(1, 60));
        endcase
        case (phase % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 81; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 81; end
            default: begin sender_idle_pct = 37; stall_pct = 37; end
        endcase
    endtask

    task automatic run_phase(input int phase);
        int  sent;
        int  pick;
        int  run;
        bit  level;
        bit  paused;
        sent   = 0;
        paused = 1'b0;
        pick_setting(phase);
        while (sent < PHASE_ITEMS)
        begin
            if (phase == 3 && !paused && sent >= PHASE_ITEMS / 2)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // Start sample, then each bit as a run that mostly agrees.
                send_random(level_sample(1'b1));
                sent++;
                for (int b = 0; b < eff_bits() && sent < PHASE_ITEMS; b++)
                begin
                    level = $urandom_range(0, 1);
                    for (int s = 0; s < eff_spb() && sent < PHASE_ITEMS; s++)
                    begin
                        send_random(level_sample(($urandom_range(0, 99) < 85) ? level
                                                                             : !level));
                        sent++;
                    end
                end
            end
            else if (pick < 85)
            begin
                run = $urandom_range(1, 8);
                for (int i = 0; i < run && sent < PHASE_ITEMS; i++)
                begin
                    send_random(sample_t'($urandom_range(0, 1023)));
                    sent++;
                end
            end
            else
            begin
                run = (eff_timeout() > 46) ? $urandom_range(1, 8)
                                           : $urandom_range(1, eff_timeout() + 2);
                for (int i = 0; i < run && sent < PHASE_ITEMS; i++)
                begin
                    send_random(level_sample(1'b0));
                    sent++;
                end
            end
        end
        drain();
    endtask

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin : check_results
        bit_result_t got;
        bit_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = '{result_ch.bit_value, result_ch.is_last, result_ch.timed_out,
                    result_ch.high_count};
            if (expected_bits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: bit %0d last %0d timeout %0d count %0d",
                             got.bit_value, got.is_last, got.timed_out, got.high_count);
            end
            else
            begin
                want = expected_bits.pop_front();
                if (got.timed_out)
                    timeouts_seen++;
                else
                    bits_seen++;
                if (got.is_last)
                    ends_seen++;
                if (got.bit_value !== want.bit_value || got.is_last !== want.is_last ||
                    got.timed_out !== want.timed_out || got.high_count !== want.high_count)
                begin
                    mismatches++;
                    // Fields in order: bit, last, timeout, count.
                    if (mismatches <= REPORT_LIMIT)
                        $display("result mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.bit_value, want.is_last, want.timed_out,
                                 want.high_count, got.bit_value, got.is_last,
                                 got.timed_out, got.high_count);
                end
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        sender_idle_pct  = 0;
        stall_pct        = 0;
        mismatches       = 0;
        bits_seen        = 0;
        ends_seen        = 0;
        timeouts_seen    = 0;
        samples_sent     = 0;
        settings_used    = 0;
        rx_threshold     = THRESHOLD_RST;
        rx_spb           = SPB_RST;
        rx_msg_bits      = MSG_BITS_RST;
        rx_timeout       = TIMEOUT_RST;
        rx_collecting    = 1'b0;
        rx_hunt          = '0;
        rx_sample_idx    = '0;
        rx_ones          = '0;
        rx_bit_idx       = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_receiver(500, 3, 2, 3);
        for (int i = 0; i < DIRECTED_LEN; i++)
            offer_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].want);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(p);

        if (expected_bits.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", expected_bits.size());
        end
        $display("Sent %0d samples across %0d register settings and four idle patterns.",
                 samples_sent, settings_used);
        $display("Compared %0d bit results (%0d message ends) and %0d timeouts.",
                 bits_seen, ends_seen, timeouts_seen);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
src/omr_pkg.sv
src/omr_if.sv
src/oversampled_majority_bit_receiver.sv
dv/oversampled_majority_bit_receiver_test.sv
